>>> hdl/coqr_pkg.sv
package coqr_pkg;

  // fixed field widths
  localparam int CH_W       = 7;
  localparam int CNT_W      = 4;
  localparam int OP_W       = 2;
  localparam int RANK_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_CHAN = 2'd1;

  localparam logic [CNT_W-1:0] SAT_LIMIT_RESET = 4'hF;
  localparam logic [CH_W-1:0]  LINK_CHAN_RESET = 7'd76;

  // commands from the controller to the datapath
  typedef struct packed {
    logic item_load;
    logic counts_clear;
    logic smp_read;
    logic smp_write;
    logic pass_init;
    logic pass_read;
    logic pass_fetch;
    logic pass_load;
    logic step_read;
    logic step_fetch;
    logic step_cmp;
    logic pass_save;
    logic link_read;
    logic link_load;
    logic emit_init;
    logic emit_load;
  } coqr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic pass_short;
    logic step_last;
    logic pass_last;
    logic emit_last;
    logic out_free;
  } coqr_sts_t;

endpackage

>>> hdl/channel_occupancy_quietest_ranker_core.sv
// channel occupancy ranker: per-channel saturating carrier-hit counts and a
// report of the quietest channels followed by the link channel's count.
// input channel (in_valid_i/in_ready_o): op_i clear, sample or report, with
// channel_i and carrier_i used by a sample. one transaction at a time.
// output channel (out_valid_o/out_ready_i): a report gives min(QUIET_COUNT,
// NUM_CHANNELS) ranked entries, quietest first, then one link entry with
// is_link_o and last_o high. clear and sample give no output.
// config channel (cfg_valid_i/cfg_ready_o): index 0 saturation limit,
// index 1 link channel; always ready. the user must write it only while
// the block is idle; the block itself does not enforce this.
// sequence: a clear resets the count valid bits; a sample reads then
// writes the count memory. a report walks the order list, each compare
// step being an order read, a count read, then a compare and swap.
// results go through an output register, so a stalled receiver only holds
// the emission; after the last entry is loaded new input is taken again.
// reset: counts read as zero (valid bits cleared), limit 15, link 76.
module channel_occupancy_quietest_ranker_core #(
  parameter int NUM_CHANNELS = 126,
  parameter int QUIET_COUNT  = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [coqr_pkg::OP_W-1:0]          op_i,
  input  logic [coqr_pkg::CH_W-1:0]          channel_i,
  input  logic                               carrier_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [coqr_pkg::RANK_W-1:0]        rank_o,
  output logic [coqr_pkg::CH_W-1:0]          chan_out_o,
  output logic [coqr_pkg::CNT_W-1:0]         occupancy_o,
  output logic                               is_link_o,
  output logic                               last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [coqr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [coqr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import coqr_pkg::*;

  coqr_cmd_t cmd;
  coqr_sts_t sts;

  // config writes are always accepted and registered directly
  assign cfg_ready_o = 1'b1;

  // sequencer: sample, clear, sort passes and emission
  coqr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // count and order memories, sort registers, output register
  coqr_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .QUIET_COUNT  (QUIET_COUNT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (op_i),
    .channel_i   (channel_i),
    .carrier_i   (carrier_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .rank_o      (rank_o),
    .chan_out_o  (chan_out_o),
    .occupancy_o (occupancy_o),
    .is_link_o   (is_link_o),
    .last_o      (last_o)
  );

endmodule

>>> hdl/coqr_ctrl.sv
module coqr_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [coqr_pkg::OP_W-1:0]    op_i,
  output logic                         in_ready_o,
  input  coqr_pkg::coqr_sts_t          sts_i,
  output coqr_pkg::coqr_cmd_t          cmd_o
);
  import coqr_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLR     = 4'd1;
  localparam logic [3:0] S_SMP_RD  = 4'd2;
  localparam logic [3:0] S_SMP_WR  = 4'd3;
  localparam logic [3:0] S_P_RD    = 4'd4;
  localparam logic [3:0] S_P_FETCH = 4'd5;
  localparam logic [3:0] S_P_LOAD  = 4'd6;
  localparam logic [3:0] S_S_RD    = 4'd7;
  localparam logic [3:0] S_S_FETCH = 4'd8;
  localparam logic [3:0] S_S_CMP   = 4'd9;
  localparam logic [3:0] S_P_SAVE  = 4'd10;
  localparam logic [3:0] S_L_RD    = 4'd11;
  localparam logic [3:0] S_L_LOAD  = 4'd12;
  localparam logic [3:0] S_EMIT    = 4'd13;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          case (op_i)
            OP_CLEAR: state_d = S_CLR;
            OP_REPORT: begin
              cmd_o.pass_init = 1'b1;
              state_d         = S_P_RD;
            end
            default: state_d = S_SMP_RD;
          endcase
        end
      end
      S_CLR: begin
        cmd_o.counts_clear = 1'b1;
        state_d            = S_IDLE;
      end
      S_SMP_RD: begin
        cmd_o.smp_read = 1'b1;
        state_d        = S_SMP_WR;
      end
      S_SMP_WR: begin
        cmd_o.smp_write = 1'b1;
        state_d         = S_IDLE;
      end
      S_P_RD: begin
        cmd_o.pass_read = 1'b1;
        state_d         = S_P_FETCH;
      end
      S_P_FETCH: begin
        cmd_o.pass_fetch = 1'b1;
        state_d          = S_P_LOAD;
      end
      S_P_LOAD: begin
        cmd_o.pass_load = 1'b1;
        state_d         = sts_i.pass_short ? S_P_SAVE : S_S_RD;
      end
      S_S_RD: begin
        cmd_o.step_read = 1'b1;
        state_d         = S_S_FETCH;
      end
      S_S_FETCH: begin
        cmd_o.step_fetch = 1'b1;
        state_d          = S_S_CMP;
      end
      S_S_CMP: begin
        cmd_o.step_cmp = 1'b1;
        state_d        = sts_i.step_last ? S_P_SAVE : S_S_RD;
      end
      S_P_SAVE: begin
        cmd_o.pass_save = 1'b1;
        state_d         = sts_i.pass_last ? S_L_RD : S_P_RD;
      end
      S_L_RD: begin
        cmd_o.link_read = 1'b1;
        state_d         = S_L_LOAD;
      end
      S_L_LOAD: begin
        cmd_o.link_load = 1'b1;
        cmd_o.emit_init = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> hdl/coqr_dpath.sv
module coqr_dpath #(
  parameter int NUM_CHANNELS = 126,
  parameter int QUIET_COUNT  = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  coqr_pkg::coqr_cmd_t                cmd_i,
  output coqr_pkg::coqr_sts_t                sts_o,
  input  logic [coqr_pkg::OP_W-1:0]          op_i,
  input  logic [coqr_pkg::CH_W-1:0]          channel_i,
  input  logic                               carrier_i,
  input  logic                               cfg_valid_i,
  input  logic [coqr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [coqr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [coqr_pkg::RANK_W-1:0]        rank_o,
  output logic [coqr_pkg::CH_W-1:0]          chan_out_o,
  output logic [coqr_pkg::CNT_W-1:0]         occupancy_o,
  output logic                               is_link_o,
  output logic                               last_o
);
  import coqr_pkg::*;

  localparam int AW     = $clog2(NUM_CHANNELS);
  localparam int RANKED = (QUIET_COUNT < NUM_CHANNELS) ? QUIET_COUNT : NUM_CHANNELS;
  localparam int RW     = (RANKED > 1) ? $clog2(RANKED) : 1;
  localparam int EW     = $clog2(RANKED + 1);

  // configuration
  logic [CNT_W-1:0] sat_q;
  logic [CH_W-1:0]  link_q;

  // latched item
  logic [CH_W-1:0] item_ch_q;
  logic            smp_en_q;

  // occupancy store with per-entry valid bits
  logic [CNT_W-1:0]        cnt_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] cnt_valid_q;
  logic [CNT_W-1:0]        cnt_rd_q;
  logic                    cnt_hit_q;
  logic [AW-1:0]           cnt_ra;
  logic [CNT_W-1:0]        cnt_val;
  logic                    cnt_we;
  logic [CNT_W-1:0]        cnt_wd;

  // order list
  logic [AW-1:0] ord_mem [NUM_CHANNELS];
  logic [AW-1:0] ord_rd_q;
  logic [AW-1:0] ord_ra;
  logic [AW-1:0] ord_wd;

  // sort walk
  logic [RW-1:0]    i_q;
  logic [AW-1:0]    j_q;
  logic [AW-1:0]    i_ext;
  logic [AW-1:0]    cand_d;
  logic [AW-1:0]    cand_q;
  logic [AW-1:0]    cur_q;
  logic [CNT_W-1:0] cur_cnt_q;
  logic             less;
  logic [AW-1:0]    rank_ch_q  [RANKED];
  logic [CNT_W-1:0] rank_cnt_q [RANKED];

  // link entry and emission
  logic             link_in;
  logic [CNT_W-1:0] link_cnt_q;
  logic [EW-1:0]    e_q;
  logic [RW-1:0]    e_idx;
  logic             e_last;

  // output register
  logic             out_valid_q;
  logic [RANK_W-1:0] rank_q;
  logic [CH_W-1:0]  chan_q;
  logic [CNT_W-1:0] occ_q;
  logic             is_link_q;
  logic             last_q;

  assign i_ext   = AW'(i_q);
  assign link_in = ({1'b0, link_q} < (CH_W + 1)'(NUM_CHANNELS));
  assign cnt_val = cnt_hit_q ? cnt_rd_q : '0;
  assign less    = (cnt_val < cur_cnt_q);
  assign e_idx   = e_q[RW-1:0];
  assign e_last  = (e_q == EW'(RANKED));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q  <= SAT_LIMIT_RESET;
      link_q <= LINK_CHAN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SAT_LIMIT: sat_q  <= cfg_data_i[CNT_W-1:0];
        CFG_LINK_CHAN: link_q <= cfg_data_i[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      item_ch_q <= channel_i;
      smp_en_q  <= (op_i == OP_SAMPLE) && carrier_i &&
                   ({1'b0, channel_i} < (CH_W + 1)'(NUM_CHANNELS));
    end
  end

  // count read address
  always_comb begin
    cand_d = ord_rd_q;
    if (i_q == '0) begin
      cand_d = cmd_i.pass_fetch ? i_ext : j_q;
    end
    cnt_ra = '0;
    if (cmd_i.smp_read && smp_en_q) begin
      cnt_ra = item_ch_q[AW-1:0];
    end else if (cmd_i.pass_fetch || cmd_i.step_fetch) begin
      cnt_ra = cand_d;
    end else if (cmd_i.link_read && link_in) begin
      cnt_ra = link_q[AW-1:0];
    end
  end

  assign cnt_we = cmd_i.smp_write && smp_en_q && (cnt_val < sat_q);
  assign cnt_wd = cnt_val + CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[item_ch_q[AW-1:0]] <= cnt_wd;
    end
    cnt_rd_q  <= cnt_mem[cnt_ra];
    cnt_hit_q <= cnt_valid_q[cnt_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_valid_q <= '0;
    end else if (cmd_i.counts_clear) begin
      cnt_valid_q <= '0;
    end else if (cnt_we) begin
      cnt_valid_q[item_ch_q[AW-1:0]] <= 1'b1;
    end
  end

  // order list: first pass reads the identity and writes every later entry
  assign ord_ra = cmd_i.pass_read ? i_ext : j_q;
  assign ord_wd = less ? cur_q : cand_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_cmp) begin
      ord_mem[j_q] <= ord_wd;
    end
    if (cmd_i.pass_read || cmd_i.step_read) begin
      ord_rd_q <= ord_mem[ord_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else begin
      if (cmd_i.pass_init) begin
        i_q <= '0;
      end else if (cmd_i.pass_save) begin
        i_q <= sts_o.pass_last ? '0 : i_q + RW'(1);
      end
      if (cmd_i.pass_load) begin
        j_q <= i_ext + AW'(1);
      end else if (cmd_i.step_cmp) begin
        j_q <= j_q + AW'(1);
      end else if (cmd_i.pass_save) begin
        j_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pass_fetch) begin
      cur_q <= cand_d;
    end
    if (cmd_i.step_fetch) begin
      cand_q <= cand_d;
    end
    if (cmd_i.pass_load) begin
      cur_cnt_q <= cnt_val;
    end
    if (cmd_i.step_cmp && less) begin
      cur_q     <= cand_q;
      cur_cnt_q <= cnt_val;
    end
    if (cmd_i.pass_save) begin
      rank_ch_q[i_q]  <= cur_q;
      rank_cnt_q[i_q] <= cur_cnt_q;
    end
    if (cmd_i.link_load) begin
      link_cnt_q <= link_in ? cnt_val : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit_init) begin
        e_q <= '0;
      end else if (cmd_i.emit_load) begin
        e_q <= e_last ? '0 : e_q + EW'(1);
      end
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      if (e_last) begin
        rank_q    <= '0;
        chan_q    <= link_q;
        occ_q     <= link_cnt_q;
        is_link_q <= 1'b1;
        last_q    <= 1'b1;
      end else begin
        rank_q    <= RANK_W'(e_q);
        chan_q    <= CH_W'(rank_ch_q[e_idx]);
        occ_q     <= rank_cnt_q[e_idx];
        is_link_q <= 1'b0;
        last_q    <= 1'b0;
      end
    end
  end

  assign sts_o.pass_short = (({1'b0, i_ext} + (AW + 1)'(1)) >= (AW + 1)'(NUM_CHANNELS));
  assign sts_o.step_last  = (j_q == AW'(NUM_CHANNELS - 1));
  assign sts_o.pass_last  = (i_q == RW'(RANKED - 1));
  assign sts_o.emit_last  = e_last;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign rank_o      = rank_q;
  assign chan_out_o  = chan_q;
  assign occupancy_o = occ_q;
  assign is_link_o   = is_link_q;
  assign last_o      = last_q;

endmodule

>>> hdl/coqr_checker.sv
module coqr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [coqr_pkg::RANK_W-1:0]   rank_o,
  input logic [coqr_pkg::CH_W-1:0]     chan_out_o,
  input logic [coqr_pkg::CNT_W-1:0]    occupancy_o,
  input logic                          is_link_o,
  input logic                          last_o
);
  import coqr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
    $stable({rank_o, chan_out_o, occupancy_o, is_link_o, last_o}))
    else $error("result changed while stalled");

  // only the link entry closes a report
  a_last_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == is_link_o))
    else $error("last flag not on link entry");

  a_link_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_link_o |-> (rank_o == '0))
    else $error("link entry with nonzero rank");

  // ranked entries follow back to back in rising order
  a_rank_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o &&
    (is_link_o || (rank_o == $past(rank_o) + RANK_W'(1))))
    else $error("rank sequence broken");

  // the block is busy in the cycle after it accepts a transaction
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

endmodule

bind channel_occupancy_quietest_ranker_core coqr_checker u_coqr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .rank_o      (rank_o),
  .chan_out_o  (chan_out_o),
  .occupancy_o (occupancy_o),
  .is_link_o   (is_link_o),
  .last_o      (last_o)
);
